// File: hdl/npcm_pkg.sv
package npcm_pkg;

  // Table geometry
  localparam int MAX_TILES = 256;
  localparam int IDX_W     = $clog2(MAX_TILES);
  localparam int COLOR_W   = 8;
  localparam int ENTRY_W   = 3 * COLOR_W;
  localparam int SQ_W      = 2 * COLOR_W;
  localparam int DIST_W    = 18;
  localparam int COUNT_W   = 9;

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_MATCH = 1'b1;

  // Configuration register indexes
  localparam logic REG_TILE_COUNT = 1'b0;

  // One classified command
  typedef struct packed {
    logic               is_match;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [IDX_W-1:0]   last;
  } cmd_t;

  // Square of the absolute difference of two color components
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{COLOR_W{1'b0}}, d} * {{COLOR_W{1'b0}}, d};
  endfunction

endpackage

// File: hdl/npcm_in_if.sv
interface npcm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [npcm_pkg::IDX_W-1:0]    entry_index;
  logic [npcm_pkg::COLOR_W-1:0]  red;
  logic [npcm_pkg::COLOR_W-1:0]  green;
  logic [npcm_pkg::COLOR_W-1:0]  blue;

  modport source (output valid, func, entry_index, red, green, blue, input ready);
  modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

// File: hdl/npcm_out_if.sv
interface npcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [npcm_pkg::IDX_W-1:0]    best_index;
  logic [npcm_pkg::DIST_W-1:0]   best_distance_sq;

  modport source (output valid, best_index, best_distance_sq, input ready);
  modport sink   (input valid, best_index, best_distance_sq, output ready);
endinterface

// File: hdl/npcm_ram.sv
module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/npcm_front.sv
module npcm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [npcm_pkg::COUNT_W-1:0]      tile_count,
  npcm_in_if.sink                           in_ch,
  output logic                              q_valid,
  output npcm_pkg::cmd_t                    q_cmd,
  input  logic                              q_pop
);

  npcm_pkg::cmd_t                   q_mem_r [npcm_pkg::QDEPTH];
  logic [npcm_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [npcm_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [npcm_pkg::QCNT_W-1:0]      count_r;
  logic [npcm_pkg::QCNT_W-1:0]      count_nxt;
  npcm_pkg::cmd_t                   cmd;
  logic [npcm_pkg::IDX_W-1:0]       last_idx;
  logic                             in_range;
  logic                             accept;
  logic                             push;

  // Clamp the search count to 1 .. MAX_TILES and keep the last index
  always_comb begin
    if (tile_count == '0) begin
      last_idx = '0;
    end else if (tile_count >= npcm_pkg::COUNT_W'(npcm_pkg::MAX_TILES)) begin
      last_idx = npcm_pkg::IDX_W'(npcm_pkg::MAX_TILES - 1);
    end else begin
      last_idx = npcm_pkg::IDX_W'(tile_count - npcm_pkg::COUNT_W'(1));
    end
  end

  // Classify the incoming transfer
  assign in_range = ({1'b0, in_ch.entry_index} < (npcm_pkg::IDX_W + 1)'(npcm_pkg::MAX_TILES));
  assign cmd.is_match = (in_ch.func == npcm_pkg::FUNC_MATCH);
  assign cmd.idx      = in_ch.entry_index;
  assign cmd.red      = in_ch.red;
  assign cmd.green    = in_ch.green;
  assign cmd.blue     = in_ch.blue;
  assign cmd.last     = last_idx;

  assign in_ch.ready = (count_r != npcm_pkg::QCNT_W'(npcm_pkg::QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  // Drop loads that fall outside the table
  assign push        = accept && (cmd.is_match || in_range);

  assign q_valid = (count_r != '0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + npcm_pkg::QCNT_W'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - npcm_pkg::QCNT_W'(1);
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + npcm_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + npcm_pkg::QPTR_W'(1);
      end
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// File: hdl/npcm_back.sv
module npcm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  npcm_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  npcm_out_if.source      out_ch
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                       state_r;
  logic [1:0]                       state_nxt;
  logic [npcm_pkg::IDX_W-1:0]       k_r;
  logic [npcm_pkg::IDX_W-1:0]       last_r;
  logic [npcm_pkg::COLOR_W-1:0]     pix_red_r;
  logic [npcm_pkg::COLOR_W-1:0]     pix_green_r;
  logic [npcm_pkg::COLOR_W-1:0]     pix_blue_r;
  logic                             v1_r;
  logic                             last1_r;
  logic [npcm_pkg::IDX_W-1:0]       idx1_r;
  logic                             v2_r;
  logic                             last2_r;
  logic [npcm_pkg::IDX_W-1:0]       idx2_r;
  logic [npcm_pkg::SQ_W-1:0]        sq_red_r;
  logic [npcm_pkg::SQ_W-1:0]        sq_green_r;
  logic [npcm_pkg::SQ_W-1:0]        sq_blue_r;
  logic [npcm_pkg::DIST_W-1:0]      best_d_r;
  logic [npcm_pkg::IDX_W-1:0]       best_i_r;
  logic                             out_valid_r;
  logic [npcm_pkg::IDX_W-1:0]       out_idx_r;
  logic [npcm_pkg::DIST_W-1:0]      out_dist_r;
  logic [npcm_pkg::ENTRY_W-1:0]     rdata;
  logic                             ram_we;
  logic                             ram_re;
  logic                             start;
  logic [npcm_pkg::DIST_W-1:0]      dist_sum;
  logic                             better;
  logic                             out_load;

  // Take one command whenever the engine is idle
  assign q_pop  = (state_r == ST_IDLE) && q_valid;
  assign ram_we = q_pop && !q_cmd.is_match;
  assign start  = q_pop && q_cmd.is_match;
  assign ram_re = (state_r == ST_SCAN);

  npcm_ram #(
    .WIDTH (npcm_pkg::ENTRY_W),
    .DEPTH (npcm_pkg::MAX_TILES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.idx),
    .wdata ({q_cmd.red, q_cmd.green, q_cmd.blue}),
    .re    (ram_re),
    .raddr (k_r),
    .rdata (rdata)
  );

  // Sum the registered squares and compare against the running best
  assign dist_sum = {2'b00, sq_red_r} + {2'b00, sq_green_r} + {2'b00, sq_blue_r};
  assign better   = v2_r && (dist_sum < best_d_r);

  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v2_r && last2_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control: state, pipeline valids, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= ram_re;
      v2_r    <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: scan index, squares, running best, output register
  always_ff @(posedge clk) begin
    if (start) begin
      k_r         <= '0;
      last_r      <= q_cmd.last;
      pix_red_r   <= q_cmd.red;
      pix_green_r <= q_cmd.green;
      pix_blue_r  <= q_cmd.blue;
      best_d_r    <= '1;
      best_i_r    <= '0;
    end else begin
      if (ram_re) begin
        k_r <= k_r + npcm_pkg::IDX_W'(1);
      end
      if (better) begin
        best_d_r <= dist_sum;
        best_i_r <= idx2_r;
      end
    end
    last1_r    <= ram_re && (k_r == last_r);
    idx1_r     <= k_r;
    last2_r    <= last1_r;
    idx2_r     <= idx1_r;
    sq_red_r   <= npcm_pkg::sq_diff(pix_red_r,
                                    rdata[npcm_pkg::ENTRY_W-1 -: npcm_pkg::COLOR_W]);
    sq_green_r <= npcm_pkg::sq_diff(pix_green_r,
                                    rdata[2*npcm_pkg::COLOR_W-1 -: npcm_pkg::COLOR_W]);
    sq_blue_r  <= npcm_pkg::sq_diff(pix_blue_r, rdata[npcm_pkg::COLOR_W-1:0]);
    if (out_load) begin
      out_idx_r  <= best_i_r;
      out_dist_r <= best_d_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.best_index       = out_idx_r;
  assign out_ch.best_distance_sq = out_dist_r;

endmodule

// File: hdl/nearest_palette_colour_match.sv
// Channel | Dir | Handshake          | Payload
// in_ch   | in  | valid/ready        | func, entry_index, red, green, blue
// out_ch  | out | valid/ready        | best_index, best_distance_sq
// cfg_*   | in  | APB, pready tied 1 | tile_count at address 0
//
// A load is written to the table when the back end pops it (one table write port).
// A match scans n entries, n being tile_count clamped to 1..256, in order: the pop,
// one table read per entry, the pipeline drain and the output load.
// Reset clears control and sets tile_count to 1; table contents stay undefined.
// A two-entry command queue lets input transfers continue while the back end
// scans; a match waits in its output load cycle while an older result stalls.
module nearest_palette_colour_match (
  input  logic                        clk,
  input  logic                        rst_n,
  npcm_in_if.sink                     in_ch,
  npcm_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [npcm_pkg::COUNT_W-1:0] tile_count_r;
  logic                         cfg_wr;
  logic                         q_valid;
  npcm_pkg::cmd_t               q_cmd;
  logic                         q_pop;

  // Register write on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_count_r <= npcm_pkg::COUNT_W'(1);
    end else if (cfg_wr && (cfg_paddr[2] == npcm_pkg::REG_TILE_COUNT)) begin
      tile_count_r <= cfg_pwdata[npcm_pkg::COUNT_W-1:0];
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == npcm_pkg::REG_TILE_COUNT) begin
      cfg_prdata = {{(32 - npcm_pkg::COUNT_W){1'b0}}, tile_count_r};
    end
  end

  npcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .tile_count (tile_count_r),
    .in_ch      (in_ch),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  npcm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hdl/npcm_checker.sv
module npcm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [npcm_pkg::IDX_W-1:0]       out_best_index,
  input logic [npcm_pkg::DIST_W-1:0]      out_best_distance_sq
);

  localparam logic [npcm_pkg::DIST_W-1:0] MAX_DIST = 18'd195075;

  // Result valid holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_best_index) && $stable(out_best_distance_sq))
    else $error("result payload changed while stalled");

  // Distance never exceeds three full-scale squared differences
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_distance_sq <= MAX_DIST)
    else $error("distance out of range");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_palette_colour_match npcm_checker u_npcm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_best_index       (out_ch.best_index),
  .out_best_distance_sq (out_ch.best_distance_sq)
);
